>>> hw/rtl/cau_pkg.sv
// Shared types, codes and constants of the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int CAU_WORD_BITS     = 32;
  localparam int CAU_FRACTION_BITS = 16;
  localparam int CAU_EXP_BITS      = 8;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4,
    CMD_POW = 3'd5,
    CMD_MAG = 3'd6
  } cau_op_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DIV_ZERO = 2'd1,
    STS_NEG_EXP  = 2'd2,
    STS_SAT      = 2'd3
  } cau_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_MWAIT,
    ST_DEN,
    ST_DIV,
    ST_DWAIT,
    ST_PUPD,
    ST_PCHK,
    ST_SQRT,
    ST_SWAIT,
    ST_FIN
  } cau_state_e;

  typedef enum logic [2:0] {
    PH_MUL,
    PH_DEN,
    PH_DIVN,
    PH_POW,
    PH_MAG
  } cau_phase_e;

  typedef enum logic [3:0] {
    MP_AR_BR,
    MP_AI_BI,
    MP_AR_BI,
    MP_AI_BR,
    MP_BR_BR,
    MP_BI_BI,
    MP_AR_AR,
    MP_AI_AI,
    MP_RR_AR,
    MP_RI_AI,
    MP_RR_AI,
    MP_RI_AR
  } cau_pair_e;

  typedef enum logic [1:0] {
    UNIT_MUL,
    UNIT_DIV,
    UNIT_SQRT
  } cau_unit_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
    logic signed [7:0]  exponent;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [31:0]        magnitude;
    logic               equal_flag;
    logic [1:0]         status;
  } cau_out_t;

  typedef struct packed {
    logic      load;
    logic      mul_start;
    cau_pair_e mul_pair;
    logic [1:0] mul_dst;
    logic      den_load;
    logic      div_start;
    logic      div_part;
    logic      sqrt_start;
    logic      pow_update;
    logic      fin;
  } cau_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       b_zero;
    logic       exp_neg;
    logic       pow_zero;
    logic       unit_done;
  } cau_stat_t;

endpackage

>>> hw/rtl/cau_chan_if.sv
// Valid/ready channel that carries one request or result payload.
`timescale 1ns / 1ps
interface cau_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: controller, datapath and checks.
// Add, sub, equal and unused codes skip the shift-add and root units.
// Divide forms |b|^2, then the numerator products, then both quotient parts;
// magnitude takes the root of |a|^2; power repeats a multiply per exponent step.
// One request at a time; the shift-add multiplier and divider loops set the rate.
// Reset is asynchronous and clears the controller and the result valid flag.
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
  parameter int WORD_BITS     = cau_pkg::CAU_WORD_BITS,
  parameter int FRACTION_BITS = cau_pkg::CAU_FRACTION_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cau_chan_if.sink      req_i,
  cau_chan_if.source    rsp_o
);
  import cau_pkg::*;

  cau_cmd_t  cmd;
  cau_stat_t stat;
  cau_out_t  out_pl;

  cau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  cau_datapath #(
    .WordBits (WORD_BITS),
    .FracBits (FRACTION_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_i.payload),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_pl)
  );

  assign rsp_o.payload = out_pl;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while a request was in work");

  a_div_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.status == STS_DIV_ZERO |->
      rsp_o.payload.result_real == 0 && rsp_o.payload.result_imag == 0)
    else $error("divide by zero returned a nonzero result");

  a_equal_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.equal_flag |->
      rsp_o.payload.status == STS_OK && rsp_o.payload.magnitude == 0)
    else $error("equality result carries other fields");

endmodule

>>> hw/rtl/cau_ctrl.sv
// Controller state machine that sequences the multiply, divide and root steps.
`timescale 1ns / 1ps
module cau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cau_pkg::cau_cmd_t cmd_o,
  input  cau_pkg::cau_stat_t stat_i
);
  import cau_pkg::*;

  cau_state_e state_q, state_d;
  cau_phase_e phase_q, phase_d;
  logic [1:0] job_q, job_d;
  logic       part_q, part_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] job_last;

  function automatic cau_pair_e pair_of(cau_phase_e ph, logic [1:0] j);
    cau_pair_e p;
    p = MP_AR_BR;
    unique case (ph)
      PH_MUL: begin
        unique case (j)
          2'd0: p = MP_AR_BR;
          2'd1: p = MP_AI_BI;
          2'd2: p = MP_AR_BI;
          default: p = MP_AI_BR;
        endcase
      end
      PH_DEN: p = j[0] ? MP_BI_BI : MP_BR_BR;
      PH_DIVN: begin
        unique case (j)
          2'd0: p = MP_AR_BR;
          2'd1: p = MP_AI_BI;
          2'd2: p = MP_AI_BR;
          default: p = MP_AR_BI;
        endcase
      end
      PH_POW: begin
        unique case (j)
          2'd0: p = MP_RR_AR;
          2'd1: p = MP_RI_AI;
          2'd2: p = MP_RR_AI;
          default: p = MP_RI_AR;
        endcase
      end
      PH_MAG: p = j[0] ? MP_AI_AI : MP_AR_AR;
      default: p = MP_AR_BR;
    endcase
    return p;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MUL;
      job_q       <= 2'd0;
      part_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      job_q       <= job_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign job_last = (phase_q == PH_DEN || phase_q == PH_MAG) ? 2'd1 : 2'd3;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    job_d       = job_q;
    part_d      = part_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.mul_pair = pair_of(phase_q, job_q);
    cmd_o.mul_dst  = job_q;
    cmd_o.div_part = part_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        job_d = 2'd0;
        case (stat_i.op)
          CMD_MUL: begin
            phase_d = PH_MUL;
            state_d = ST_MUL;
          end
          CMD_DIV: begin
            phase_d = PH_DEN;
            state_d = stat_i.b_zero ? ST_FIN : ST_MUL;
          end
          CMD_POW: state_d = stat_i.exp_neg ? ST_FIN : ST_PCHK;
          CMD_MAG: begin
            phase_d = PH_MAG;
            state_d = ST_MUL;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat_i.unit_done) begin
          if (job_q == job_last) begin
            unique case (phase_q)
              PH_MUL:  state_d = ST_FIN;
              PH_DEN:  state_d = ST_DEN;
              PH_DIVN: begin
                part_d  = 1'b0;
                state_d = ST_DIV;
              end
              PH_POW:  state_d = ST_PUPD;
              PH_MAG:  state_d = ST_SQRT;
              default: state_d = ST_FIN;
            endcase
          end else begin
            job_d   = job_q + 2'd1;
            state_d = ST_MUL;
          end
        end
      end
      ST_DEN: begin
        cmd_o.den_load = 1'b1;
        phase_d        = PH_DIVN;
        job_d          = 2'd0;
        state_d        = ST_MUL;
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat_i.unit_done) begin
          if (part_q) begin
            state_d = ST_FIN;
          end else begin
            part_d  = 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_PUPD: begin
        cmd_o.pow_update = 1'b1;
        state_d          = ST_PCHK;
      end
      ST_PCHK: begin
        if (stat_i.pow_zero) begin
          state_d = ST_FIN;
        end else begin
          phase_d = PH_POW;
          job_d   = 2'd0;
          state_d = ST_MUL;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (stat_i.unit_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/cau_datapath.sv
// Datapath with operand registers, shift-add multiplier, divider and root unit.
`timescale 1ns / 1ps
module cau_datapath #(
  parameter int WordBits = cau_pkg::CAU_WORD_BITS,
  parameter int FracBits = cau_pkg::CAU_FRACTION_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cau_pkg::cau_in_t   in_i,
  input  cau_pkg::cau_cmd_t  cmd_i,
  output cau_pkg::cau_stat_t stat_o,
  output cau_pkg::cau_out_t  out_o
);
  import cau_pkg::*;

  localparam int W  = WordBits;
  localparam int F  = FracBits;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int QW = PW + F;
  localparam int CW = $clog2(QW + 1);
  localparam logic [QW-1:0] MaxP = {{(QW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [QW-1:0] MaxN = MaxP + QW'(1);
  localparam logic [QW-1:0] OneMag = QW'(1) << F;
  localparam logic [CW-1:0] MulLast = CW'(W - 1);
  localparam logic [CW-1:0] DivLast = CW'(QW - 1);

  function automatic logic [W:0] sat_word(logic neg, logic [QW-1:0] mag);
    logic [QW-1:0] t;
    logic [W:0]    r;
    t = ~mag + QW'(1);
    if (neg) begin
      r = (mag > MaxN) ? {1'b1, 1'b1, {(W - 1){1'b0}}} : {1'b0, t[W-1:0]};
    end else begin
      r = (mag > MaxP) ? {1'b1, 1'b0, {(W - 1){1'b1}}} : {1'b0, mag[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] abs_s(logic signed [SW-1:0] v);
    return v[SW-1] ? (~v + SW'(1)) : v;
  endfunction

  function automatic logic [W:0] sat_sig(logic signed [SW-1:0] v);
    return sat_word(v[SW-1], QW'(abs_s(v)));
  endfunction

  function automatic logic [W:0] rescale(logic signed [SW-1:0] v);
    logic [SW-1:0] a;
    a = abs_s(v) >> F;
    return sat_word(v[SW-1], QW'(a));
  endfunction

  localparam logic [W:0] OneWord = sat_word(1'b0, OneMag);

  cau_op_e op_q;
  logic signed [W-1:0] ar_q, ai_q, br_q, bi_q, rr_q, ri_q;
  logic [6:0]          pcnt_q;
  logic                exneg_q, sat_q;
  logic signed [PW-1:0] p_q [4];
  logic [PW-1:0]       den_q;
  logic [W-1:0]        mag_q;
  cau_out_t            out_q;

  cau_unit_e           unit_q;
  logic                busy_q, done_q, neg_q, part_q;
  logic [1:0]          dst_q;
  logic [CW-1:0]       cnt_q;
  logic [PW-1:0]       acc_q;
  logic [W-1:0]        mcand_q;
  logic [QW-1:0]       dsr_q;
  logic [PW-1:0]       rem_q;
  logic [PW-1:0]       sreg_q;
  logic [W+1:0]        srem_q;
  logic [W-1:0]        root_q;

  logic signed [W-1:0]  opx, opy;
  logic [W-1:0]         mx, my;
  logic signed [SW-1:0] sum01, dif01, sum23, dif23, num;
  logic [W:0]           msum;
  logic [PW-1:0]        acc_step;
  logic [SW-1:0]        r2, rdiff;
  logic                 ge;
  logic [W+1:0]         sr, trial, sdiff;
  logic                 sge;
  logic                 last;
  logic [W:0]           w_re, w_im, w_div, w_pre, w_pim;
  logic signed [W:0]    add_re, add_im, sub_re, sub_im;
  logic [SW-1:0]        num_abs;
  cau_out_t             fin_d;

  always_comb begin
    unique case (cmd_i.mul_pair)
      MP_AR_BR: begin opx = ar_q; opy = br_q; end
      MP_AI_BI: begin opx = ai_q; opy = bi_q; end
      MP_AR_BI: begin opx = ar_q; opy = bi_q; end
      MP_AI_BR: begin opx = ai_q; opy = br_q; end
      MP_BR_BR: begin opx = br_q; opy = br_q; end
      MP_BI_BI: begin opx = bi_q; opy = bi_q; end
      MP_AR_AR: begin opx = ar_q; opy = ar_q; end
      MP_AI_AI: begin opx = ai_q; opy = ai_q; end
      MP_RR_AR: begin opx = rr_q; opy = ar_q; end
      MP_RI_AI: begin opx = ri_q; opy = ai_q; end
      MP_RR_AI: begin opx = rr_q; opy = ai_q; end
      MP_RI_AR: begin opx = ri_q; opy = ar_q; end
      default:  begin opx = ar_q; opy = br_q; end
    endcase
    mx = opx[W-1] ? (~opx + W'(1)) : opx;
    my = opy[W-1] ? (~opy + W'(1)) : opy;
  end

  assign sum01 = SW'(p_q[0]) + SW'(p_q[1]);
  assign dif01 = SW'(p_q[0]) - SW'(p_q[1]);
  assign sum23 = SW'(p_q[2]) + SW'(p_q[3]);
  assign dif23 = SW'(p_q[2]) - SW'(p_q[3]);
  assign num     = cmd_i.div_part ? dif23 : sum01;
  assign num_abs = abs_s(num);

  assign msum     = {1'b0, acc_q[PW-1:W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
  assign acc_step = {msum, acc_q[W-1:1]};

  assign r2    = {rem_q, dsr_q[QW-1]};
  assign rdiff = r2 - {1'b0, den_q};
  assign ge    = ~rdiff[SW-1];

  assign sr    = {srem_q[W-1:0], sreg_q[PW-1:PW-2]};
  assign trial = {root_q, 2'b01};
  assign sdiff = sr - trial;
  assign sge   = sr >= trial;

  assign last = (unit_q == UNIT_DIV) ? (cnt_q == DivLast) : (cnt_q == MulLast);

  assign w_re  = rescale(dif01);
  assign w_im  = rescale(sum23);
  assign w_div = sat_word(neg_q, dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      unit_q <= UNIT_MUL;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.mul_start || cmd_i.div_start || cmd_i.sqrt_start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        unit_q <= cmd_i.div_start ? UNIT_DIV : (cmd_i.sqrt_start ? UNIT_SQRT : UNIT_MUL);
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= cau_op_e'(in_i.command);
      ar_q    <= W'($unsigned(in_i.a_real));
      ai_q    <= W'($unsigned(in_i.a_imag));
      br_q    <= W'($unsigned(in_i.b_real));
      bi_q    <= W'($unsigned(in_i.b_imag));
      exneg_q <= in_i.exponent[7];
      pcnt_q  <= in_i.exponent[6:0];
      rr_q    <= OneWord[W-1:0];
      ri_q    <= '0;
      mag_q   <= '0;
      sat_q   <= (cau_op_e'(in_i.command) == CMD_POW) & ~in_i.exponent[7] & OneWord[W];
    end
    if (cmd_i.mul_start) begin
      dst_q   <= cmd_i.mul_dst;
      neg_q   <= opx[W-1] ^ opy[W-1];
      mcand_q <= mx;
      acc_q   <= {{W{1'b0}}, my};
    end
    if (cmd_i.div_start) begin
      part_q <= cmd_i.div_part;
      neg_q  <= num[SW-1];
      rem_q  <= '0;
      dsr_q  <= {num_abs[PW-1:0], {F{1'b0}}};
    end
    if (cmd_i.sqrt_start) begin
      sreg_q <= sum01[PW-1:0];
      srem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.den_load) begin
      den_q <= sum01[PW-1:0];
    end
    if (cmd_i.pow_update) begin
      rr_q   <= w_re[W-1:0];
      ri_q   <= w_im[W-1:0];
      sat_q  <= sat_q | w_re[W] | w_im[W];
      pcnt_q <= pcnt_q - 7'd1;
    end
    if (busy_q) begin
      unique case (unit_q)
        UNIT_MUL: acc_q <= acc_step;
        UNIT_DIV: begin
          rem_q <= ge ? rdiff[PW-1:0] : r2[PW-1:0];
          dsr_q <= {dsr_q[QW-2:0], ge};
        end
        UNIT_SQRT: begin
          srem_q <= sge ? sdiff : sr;
          root_q <= {root_q[W-2:0], sge};
          sreg_q <= sreg_q << 2;
        end
        default: acc_q <= acc_q;
      endcase
    end
    if (done_q) begin
      unique case (unit_q)
        UNIT_MUL: p_q[dst_q] <= neg_q ? (~acc_q + PW'(1)) : acc_q;
        UNIT_DIV: begin
          if (part_q) begin
            ri_q <= w_div[W-1:0];
          end else begin
            rr_q <= w_div[W-1:0];
          end
          sat_q <= sat_q | w_div[W];
        end
        UNIT_SQRT: mag_q <= root_q;
        default: mag_q <= mag_q;
      endcase
    end
    if (cmd_i.fin) begin
      out_q <= fin_d;
    end
  end

  assign add_re = (W+1)'(ar_q) + (W+1)'(br_q);
  assign add_im = (W+1)'(ai_q) + (W+1)'(bi_q);
  assign sub_re = (W+1)'(ar_q) - (W+1)'(br_q);
  assign sub_im = (W+1)'(ai_q) - (W+1)'(bi_q);

  always_comb begin
    logic [W-1:0] res_re, res_im;
    logic         sat;
    fin_d  = '0;
    res_re = '0;
    res_im = '0;
    sat    = 1'b0;
    w_pre  = '0;
    w_pim  = '0;
    case (op_q)
      CMD_ADD: begin
        w_pre = sat_sig(SW'(add_re));
        w_pim = sat_sig(SW'(add_im));
      end
      CMD_SUB: begin
        w_pre = sat_sig(SW'(sub_re));
        w_pim = sat_sig(SW'(sub_im));
      end
      CMD_MUL: begin
        w_pre = w_re;
        w_pim = w_im;
      end
      CMD_DIV, CMD_POW: begin
        w_pre = {sat_q, rr_q};
        w_pim = {1'b0, ri_q};
      end
      default: begin
        w_pre = {sat_q, {W{1'b0}}};
        w_pim = '0;
      end
    endcase
    res_re = w_pre[W-1:0];
    res_im = w_pim[W-1:0];
    sat    = w_pre[W] | w_pim[W];
    fin_d.result_real = 32'($signed(res_re));
    fin_d.result_imag = 32'($signed(res_im));
    fin_d.magnitude   = (op_q == CMD_MAG) ? 32'(mag_q) : 32'd0;
    fin_d.equal_flag  = (op_q == CMD_EQ) && (ar_q == br_q) && (ai_q == bi_q);
    fin_d.status      = sat ? STS_SAT : STS_OK;
    if (op_q == CMD_DIV && br_q == '0 && bi_q == '0) begin
      fin_d        = '0;
      fin_d.status = STS_DIV_ZERO;
    end
    if (op_q == CMD_POW && exneg_q) begin
      fin_d        = '0;
      fin_d.status = STS_NEG_EXP;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.b_zero    = (br_q == '0) && (bi_q == '0);
  assign stat_o.exp_neg   = exneg_q;
  assign stat_o.pow_zero  = (pcnt_q == 7'd0);
  assign stat_o.unit_done = done_q;
  assign out_o            = out_q;

endmodule

>>> bench/complex_arithmetic_unit_tb.sv
// Self-checking testbench of the complex arithmetic unit with a built-in predictor.
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  logic clk_i;
  logic rst_ni;

  cau_chan_if #(.payload_t(cau_in_t))  req_if ();
  cau_chan_if #(.payload_t(cau_out_t)) rsp_if ();

  complex_arithmetic_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cau_out_t expected_results[$];
  int       error_count;
  int       requests_sent;
  int       results_checked;
  int       hold_cycles;
  bit       steady_mode;
  int       op_count[8];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("complex_arithmetic_unit_tb NOT OK");
    $finish;
  end

  function automatic logic signed [31:0] to_word(input logic neg, input logic [127:0] mag,
                                                 inout logic sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return -mag[31:0];
    end
    if (mag > 128'h7fff_ffff) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    return mag[31:0];
  endfunction

  function automatic logic [127:0] abs_wide(input logic signed [127:0] v);
    return v[127] ? -v : v;
  endfunction

  function automatic logic signed [127:0] widen(input logic signed [31:0] v);
    logic signed [127:0] w;
    w = v;
    return w;
  endfunction

  function automatic logic signed [31:0] rescale(input logic signed [127:0] v, inout logic sat);
    return to_word(v[127], abs_wide(v) >> CAU_FRACTION_BITS, sat);
  endfunction

  task automatic complex_product(input logic signed [31:0] ar, input logic signed [31:0] ai,
                                 input logic signed [31:0] br, input logic signed [31:0] bi,
                                 output logic signed [31:0] rr, output logic signed [31:0] ri,
                                 inout logic sat);
    rr = rescale(widen(ar) * widen(br) - widen(ai) * widen(bi), sat);
    ri = rescale(widen(ar) * widen(bi) + widen(ai) * widen(br), sat);
  endtask

  function automatic logic signed [31:0] quotient_part(input logic signed [127:0] num,
                                                       input logic [127:0] den, inout logic sat);
    return to_word(num[127], (abs_wide(num) << CAU_FRACTION_BITS) / den, sat);
  endfunction

  task automatic predict_result(input cau_in_t req, output cau_out_t res);
    logic signed [31:0]  rr, ri, nr, ni;
    logic [127:0]        den, sq;
    logic [63:0]         root, trial;
    logic                sat;
    cau_status_e         sts;
    sat  = 1'b0;
    sts  = STS_OK;
    rr   = '0;
    ri   = '0;
    root = '0;
    res  = '0;
    case (req.command)
      CMD_ADD: begin
        rr = to_word(1'b0, '0, sat);
        rr = rescale((widen(req.a_real) + widen(req.b_real)) << CAU_FRACTION_BITS, sat);
        ri = rescale((widen(req.a_imag) + widen(req.b_imag)) << CAU_FRACTION_BITS, sat);
      end
      CMD_SUB: begin
        rr = rescale((widen(req.a_real) - widen(req.b_real)) << CAU_FRACTION_BITS, sat);
        ri = rescale((widen(req.a_imag) - widen(req.b_imag)) << CAU_FRACTION_BITS, sat);
      end
      CMD_MUL: complex_product(req.a_real, req.a_imag, req.b_real, req.b_imag, rr, ri, sat);
      CMD_DIV: begin
        if (req.b_real == 0 && req.b_imag == 0) begin
          sts = STS_DIV_ZERO;
        end else begin
          den = widen(req.b_real) * widen(req.b_real) + widen(req.b_imag) * widen(req.b_imag);
          rr  = quotient_part(widen(req.a_real) * widen(req.b_real)
                              + widen(req.a_imag) * widen(req.b_imag), den, sat);
          ri  = quotient_part(widen(req.a_imag) * widen(req.b_real)
                              - widen(req.a_real) * widen(req.b_imag), den, sat);
        end
      end
      CMD_EQ: res.equal_flag = (req.a_real == req.b_real) && (req.a_imag == req.b_imag);
      CMD_POW: begin
        if (req.exponent < 0) begin
          sts = STS_NEG_EXP;
        end else begin
          rr = 32'sd1 <<< CAU_FRACTION_BITS;
          for (int i = 0; i < req.exponent; i++) begin
            complex_product(rr, ri, req.a_real, req.a_imag, nr, ni, sat);
            rr = nr;
            ri = ni;
          end
        end
      end
      CMD_MAG: begin
        sq = widen(req.a_real) * widen(req.a_real) + widen(req.a_imag) * widen(req.a_imag);
        for (int b = 63; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if ({64'd0, trial} * {64'd0, trial} <= sq) root = trial;
        end
        if (root > 64'hffff_ffff) begin
          root = 64'hffff_ffff;
          sat  = 1'b1;
        end
      end
      default: ;
    endcase
    if (sts == STS_OK && sat) sts = STS_SAT;
    res.result_real = rr;
    res.result_imag = ri;
    res.magnitude   = root[31:0];
    res.status      = sts;
  endtask

  task automatic send_request(input cau_in_t req);
    cau_out_t res;
    if (!steady_mode && $urandom_range(99) < 12) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    do @(posedge clk_i); while (!req_if.ready);
    predict_result(req, res);
    expected_results.push_back(res);
    requests_sent++;
    op_count[req.command]++;
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi, input logic [7:0] ex);
    cau_in_t req;
    req.command  = cmd;
    req.a_real   = ar;
    req.a_imag   = ai;
    req.b_real   = br;
    req.b_imag   = bi;
    req.exponent = ex;
    send_request(req);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return ($urandom_range(0, 40) - 20) << CAU_FRACTION_BITS;
    endcase
  endfunction

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, actual %p", $time, rsp_if.payload);
          error_count++;
        end else begin
          cau_out_t exp_res;
          exp_res = expected_results.pop_front();
          results_checked++;
          if (rsp_if.payload.result_real !== exp_res.result_real) begin
            $display("%0t: result_real expected %h actual %h", $time,
                     exp_res.result_real, rsp_if.payload.result_real);
            error_count++;
          end
          if (rsp_if.payload.result_imag !== exp_res.result_imag) begin
            $display("%0t: result_imag expected %h actual %h", $time,
                     exp_res.result_imag, rsp_if.payload.result_imag);
            error_count++;
          end
          if (rsp_if.payload.magnitude !== exp_res.magnitude) begin
            $display("%0t: magnitude expected %h actual %h", $time,
                     exp_res.magnitude, rsp_if.payload.magnitude);
            error_count++;
          end
          if (rsp_if.payload.equal_flag !== exp_res.equal_flag) begin
            $display("%0t: equal_flag expected %b actual %b", $time,
                     exp_res.equal_flag, rsp_if.payload.equal_flag);
            error_count++;
          end
          if (rsp_if.payload.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, rsp_if.payload.status);
            error_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready <= steady_mode || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic test_extremes();
    send_fields(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 8'd0);
    send_fields(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 8'd0);
    send_fields(CMD_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 8'd0);
    send_fields(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'hff);
    send_fields(CMD_MUL, 32'hffff_ffff, 32'h0001_8000, 32'hfffe_8000, 32'h0000_0001, 8'd0);
    send_fields(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 8'd0);
    send_fields(CMD_MAG, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0, 8'd0);
    send_fields(3'd7, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 32'h1, 8'h80);
  endtask

  task automatic test_divide();
    send_fields(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 8'd0);
    send_fields(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0, 8'd0);
    send_fields(CMD_DIV, 32'hfffd_0000, 32'h0007_0000, 32'h0002_0000, 32'hffff_0000, 8'd0);
    send_fields(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0);
  endtask

  task automatic test_equality();
    send_fields(CMD_EQ, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 8'd0);
    send_fields(CMD_EQ, 32'h0005_0000, 32'h0, 32'h0005_0000, 32'h0, 8'd0);
    send_fields(CMD_EQ, 32'h0005_0000, 32'h0000_0001, 32'h0005_0000, 32'h0, 8'd0);
  endtask

  task automatic test_power();
    send_fields(CMD_POW, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 8'h80);
    send_fields(CMD_POW, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 8'hff);
    send_fields(CMD_POW, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 8'd0);
    send_fields(CMD_POW, 32'h0000_b505, 32'h0000_b505, 32'h0, 32'h0, 8'd1);
    send_fields(CMD_POW, 32'h0000_b505, 32'h0000_b505, 32'h0, 32'h0, 8'd8);
    send_fields(CMD_POW, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 8'd127);
    send_fields(CMD_POW, 32'h0003_0000, 32'hfffe_0000, 32'h0, 32'h0, 8'd127);
  endtask

  task automatic test_random(input int count);
    cau_in_t req;
    for (int n = 0; n < count; n++) begin
      steady_mode    = (n >= count / 3) && (n < count / 2);
      req.command  = 3'($urandom_range(7));
      req.a_real   = random_word();
      req.a_imag   = random_word();
      req.b_real   = random_word();
      req.b_imag   = random_word();
      if (req.command == CMD_EQ && $urandom_range(1)) begin
        req.b_real = req.a_real;
        req.b_imag = $urandom_range(1) ? req.a_imag : 32'h0;
      end
      if (req.command == CMD_DIV && $urandom_range(9) == 0) begin
        req.b_real = '0;
        req.b_imag = '0;
      end
      if ($urandom_range(9) == 0) req.exponent = 8'($urandom) | 8'h80;
      else                        req.exponent = 8'($urandom_range(0, 6));
      send_request(req);
    end
    steady_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int n = 0; n < 12; n++) begin
      send_fields(3'($urandom_range(0, 4)), random_word(), random_word(), random_word(),
                  random_word(), 8'd2);
    end
  endtask

  initial begin
    int wait_cycles;
    error_count     = 0;
    requests_sent   = 0;
    results_checked = 0;
    hold_cycles     = 0;
    steady_mode     = 1'b0;
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    rst_ni          = 1'b0;
    req_if.valid    <= 1'b0;
    req_if.payload  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_divide();
    test_equality();
    test_power();
    test_backpressure();
    test_random(1200);
    req_if.valid <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (expected_results.size() != 0) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("complex_arithmetic_unit_tb NOT OK");
      $finish;
    end else begin
      repeat (500) @(posedge clk_i);
      $display("Sent %0d requests and checked %0d results; per command: %p.",
               requests_sent, results_checked, op_count);
      $display("Covered operand extremes, division by zero, negative exponents and stalls.");
      if (error_count == 0 && expected_results.size() == 0) begin
        $display("complex_arithmetic_unit_tb OK");
      end else begin
        $display("complex_arithmetic_unit_tb NOT OK");
      end
      $finish;
    end
  end

endmodule

>>> complex_arithmetic_unit.f
hw/rtl/cau_pkg.sv
hw/rtl/cau_chan_if.sv
hw/rtl/cau_ctrl.sv
hw/rtl/cau_datapath.sv
hw/rtl/complex_arithmetic_unit.sv
bench/complex_arithmetic_unit_tb.sv
